FILE: rtl/assert_macros.svh
// Assertion macros shared by the replacement block.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge of clk while not in reset.
`define RRIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check prop on every rising edge of clk, reset included.
`define RRIP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/rrip_pkg.sv
// Shared types and constants for the RRIP replacement block with PC reuse.
// No dependencies; the modules and interfaces in the other files depend on it.
`timescale 1ns / 1ps

package rrip_pkg;

  // Field widths fixed by the request and result formats.
  localparam int SET_IDX_W = 11;
  localparam int HIT_WAY_W = 4;
  localparam int ADDR_W    = 64;
  localparam int OUT_WAY_W = 4;
  localparam int OUT_RRPV_W = 2;
  localparam int CNT_W     = 5;

  // Geometry; NUM_SETS, NUM_WAYS and PC_ENTRIES are powers of two.
  localparam int NUM_SETS   = 2048;
  localparam int NUM_WAYS   = 16;
  localparam int RRPV_MAX   = 3;
  localparam int PC_ENTRIES = 4096;

  localparam int SET_W  = $clog2(NUM_SETS);
  localparam int WAY_W  = $clog2(NUM_WAYS);
  localparam int RRPV_W = $clog2(RRPV_MAX + 1);
  localparam int PC_W   = $clog2(PC_ENTRIES);
  localparam int TAG_W  = ADDR_W - PC_W;

  localparam int CLEAR_LEN = (NUM_SETS > PC_ENTRIES) ? NUM_SETS : PC_ENTRIES;
  localparam int CLR_W     = $clog2(CLEAR_LEN);

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_REUSE_THRESH    = 1'b0;
  localparam logic REG_COUNTER_CEILING = 1'b1;
  localparam logic [CNT_W-1:0] REUSE_THRESH_RST    = CNT_W'(6);
  localparam logic [CNT_W-1:0] COUNTER_CEILING_RST = CNT_W'(31);

  typedef logic [RRPV_W-1:0] rrpv_t;
  typedef logic [NUM_WAYS-1:0][RRPV_W-1:0] rrpv_row_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] reuse_thresh;
    logic [CNT_W-1:0] counter_ceiling;
  } cfg_t;

  typedef struct packed {
    logic             rd_en;
    logic [SET_W-1:0] rd_addr;
    logic             wr_en;
    logic [SET_W-1:0] wr_addr;
    rrpv_row_t        wr_data;
  } rrpv_req_t;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic              vld;
    logic [TAG_W-1:0]  tag;
    logic [ADDR_W-1:0] addr;
  } pc_ent_t;

  typedef struct packed {
    logic              rd_en;
    logic [PC_W-1:0]   rd_idx;
    logic [PC_W-1:0]   wr_idx;
    logic              cnt_we;
    logic              vld_we;
    logic              rec_we;
    pc_ent_t           wr_data;
  } pc_req_t;

  // Lowest index whose bit is set; 0 when none is.
  function automatic logic [WAY_W-1:0] lowest_set(input logic [NUM_WAYS-1:0] v);
    logic [WAY_W-1:0] idx;
    idx = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (v[w]) idx = WAY_W'(w);
    end
    return idx;
  endfunction

endpackage

FILE: rtl/rrip_ifs.sv
// Request and result channel interfaces of the replacement block.
// Depends on rrip_pkg for field widths.
`timescale 1ns / 1ps

interface rrip_in_if;
  logic                               valid;
  logic                               ready;
  logic [rrip_pkg::SET_IDX_W-1:0]     set_index;
  logic                               hit;
  logic [rrip_pkg::HIT_WAY_W-1:0]     hit_way;
  logic [rrip_pkg::ADDR_W-1:0]        pc;
  logic [rrip_pkg::ADDR_W-1:0]        paddr;

  modport source (output valid, set_index, hit, hit_way, pc, paddr, input ready);
  modport sink   (input valid, set_index, hit, hit_way, pc, paddr, output ready);
endinterface

interface rrip_out_if;
  logic                               valid;
  logic                               ready;
  logic [rrip_pkg::OUT_WAY_W-1:0]     chosen_way;
  logic [rrip_pkg::OUT_RRPV_W-1:0]    new_rrpv;

  modport source (output valid, chosen_way, new_rrpv, input ready);
  modport sink   (input valid, chosen_way, new_rrpv, output ready);
endinterface

FILE: rtl/rrip_rrpv_mem.sv
// Re-reference value store: one row of per-way values per set.
// Synchronous memory with a registered read; depends on rrip_pkg.
`timescale 1ns / 1ps

module rrip_rrpv_mem (
  input  logic                clk,
  input  rrip_pkg::rrpv_req_t req,
  output rrip_pkg::rrpv_row_t rd_row
);
  import rrip_pkg::*;

  rrpv_row_t mem [NUM_SETS];
  rrpv_row_t rd_row_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    // Hold read data until the next read so a stalled request keeps its row.
    if (req.rd_en) begin
      rd_row_r <= mem[req.rd_addr];
    end
  end

  assign rd_row = rd_row_r;

endmodule

FILE: rtl/rrip_pc_table.sv
// Per-PC table: reuse counter, last-miss valid, tag and address.
// Synchronous memory with per-field write enables; depends on rrip_pkg.
`timescale 1ns / 1ps

module rrip_pc_table (
  input  logic              clk,
  input  rrip_pkg::pc_req_t req,
  output rrip_pkg::pc_ent_t rd_ent
);
  import rrip_pkg::*;

  pc_ent_t mem [PC_ENTRIES];
  pc_ent_t rd_ent_r;

  always_ff @(posedge clk) begin
    if (req.cnt_we) begin
      mem[req.wr_idx].cnt <= req.wr_data.cnt;
    end
    if (req.vld_we) begin
      mem[req.wr_idx].vld <= req.wr_data.vld;
    end
    if (req.rec_we) begin
      mem[req.wr_idx].tag  <= req.wr_data.tag;
      mem[req.wr_idx].addr <= req.wr_data.addr;
    end
    if (req.rd_en) begin
      rd_ent_r <= mem[req.rd_idx];
    end
  end

  assign rd_ent = rd_ent_r;

endmodule

FILE: rtl/rrip_victim.sv
// Victim selection for a miss: ages the row until a way is at the maximum
// value and picks the lowest such way. Depends on rrip_pkg.
`timescale 1ns / 1ps

module rrip_victim (
  input  rrip_pkg::rrpv_row_t           row,
  output rrip_pkg::rrpv_row_t           aged_row,
  output logic [rrip_pkg::WAY_W-1:0]    victim
);
  import rrip_pkg::*;

  logic [RRPV_MAX:0]    present;
  rrpv_t                top;
  rrpv_t                lift;
  logic [NUM_WAYS-1:0]  at_max;
  logic [RRPV_W:0]      sum;

  // Flag each level that some way holds; the top level sets the lift.
  always_comb begin
    for (int l = 0; l <= RRPV_MAX; l++) begin
      present[l] = 1'b0;
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (row[w] == RRPV_W'(l)) present[l] = 1'b1;
      end
    end
    top = RRPV_W'(RRPV_MAX);
    for (int l = 0; l < RRPV_MAX; l++) begin
      if (present[l]) top = RRPV_W'(l);
    end
    for (int l = RRPV_MAX; l >= 0; l--) begin
      if (present[l]) begin
        top = RRPV_W'(l);
        break;
      end
    end
    lift = RRPV_W'(RRPV_MAX) - top;
  end

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      sum = {1'b0, row[w]} + {1'b0, lift};
      aged_row[w] = (sum > (RRPV_W + 1)'(RRPV_MAX)) ? RRPV_W'(RRPV_MAX) : sum[RRPV_W-1:0];
      at_max[w]   = (aged_row[w] == RRPV_W'(RRPV_MAX));
    end
  end

  assign victim = lowest_set(at_max);

endmodule

FILE: rtl/rrip_cfg_regs.sv
// Configuration registers behind an APB-style port.
// Depends on rrip_pkg for the register map and reset values.
`timescale 1ns / 1ps

module rrip_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [rrip_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [rrip_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [rrip_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready,
  output rrip_pkg::cfg_t                    cfg
);
  import rrip_pkg::*;

  logic [CNT_W-1:0] reuse_thresh_r, reuse_thresh_nxt;
  logic [CNT_W-1:0] counter_ceiling_r, counter_ceiling_nxt;
  logic             wr_go;
  logic             reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_go      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_paddr[2];

  always_comb begin
    reuse_thresh_nxt    = reuse_thresh_r;
    counter_ceiling_nxt = counter_ceiling_r;
    if (wr_go) begin
      unique case (reg_sel)
        REG_REUSE_THRESH:    reuse_thresh_nxt    = cfg_pwdata[CNT_W-1:0];
        REG_COUNTER_CEILING: counter_ceiling_nxt = cfg_pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reuse_thresh_r    <= REUSE_THRESH_RST;
      counter_ceiling_r <= COUNTER_CEILING_RST;
    end else begin
      reuse_thresh_r    <= reuse_thresh_nxt;
      counter_ceiling_r <= counter_ceiling_nxt;
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_REUSE_THRESH:    cfg_prdata = CFG_DATA_W'(reuse_thresh_r);
      REG_COUNTER_CEILING: cfg_prdata = CFG_DATA_W'(counter_ceiling_r);
      default:             cfg_prdata = '0;
    endcase
  end

  assign cfg.reuse_thresh    = reuse_thresh_r;
  assign cfg.counter_ceiling = counter_ceiling_r;

endmodule

FILE: rtl/rrip_replacement_with_pc_reuse.sv
// RRIP cache replacement with per-PC reuse prediction. Each accepted access
// (set, hit flag, hit way, PC, address) yields one result: the way written and
// its new re-reference value. On accept the set's row and the PC table entry
// are read; in the execute state both are written back and the result register
// is loaded, held back while an earlier result still waits to be taken. The
// next access is taken only after the write-back, so the block cannot accept a
// new access before the read-modify-write of the two memories is through. After
// reset a clearing pass sets every row to the maximum value and zeroes the reuse
// counters and last-miss valid bits; no access is accepted during it,
// configuration writes are. Depends on rrip_pkg, rrip_ifs and the submodules.
`timescale 1ns / 1ps

module rrip_replacement_with_pc_reuse (
  input  logic                              clk,
  input  logic                              rst_n,
  rrip_in_if.sink                           in_req,
  rrip_out_if.source                        out_rsp,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [rrip_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [rrip_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [rrip_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import rrip_pkg::*;
  `include "assert_macros.svh"

  typedef struct packed {
    logic [SET_W-1:0]  set;
    logic              hit;
    logic [WAY_W-1:0]  way;
    logic [PC_W-1:0]   pidx;
    logic [TAG_W-1:0]  ptag;
    logic [ADDR_W-1:0] paddr;
  } acc_t;

  state_t           state_r, state_nxt;
  logic [CLR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             clr_last;
  acc_t             acc_r, acc_nxt;
  logic             in_go;
  logic             exec_go;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_WAY_W-1:0]  out_way_r, out_way_nxt;
  logic [OUT_RRPV_W-1:0] out_rrpv_r, out_rrpv_nxt;

  cfg_t      cfg;
  rrpv_req_t rrpv_req;
  rrpv_row_t rd_row;
  pc_req_t   pc_req;
  pc_ent_t   rd_ent;
  rrpv_row_t aged_row;
  logic [WAY_W-1:0] victim;

  // Result of the access in flight.
  logic [CNT_W:0]   cnt_inc;
  logic [CNT_W-1:0] cnt_new;
  logic             hot;
  logic             again;
  rrpv_t            new_val;
  logic [WAY_W-1:0] new_way;
  rrpv_row_t        new_row;

  rrip_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  rrip_rrpv_mem u_rrpv (
    .clk    (clk),
    .req    (rrpv_req),
    .rd_row (rd_row)
  );

  rrip_pc_table u_pct (
    .clk    (clk),
    .req    (pc_req),
    .rd_ent (rd_ent)
  );

  rrip_victim u_victim (
    .row      (rd_row),
    .aged_row (aged_row),
    .victim   (victim)
  );

  assign clr_last = (clr_cnt_r == CLR_W'(CLEAR_LEN - 1));
  assign in_go    = in_req.valid && in_req.ready;
  assign exec_go  = (state_r == ST_EXEC) && (!out_valid_r || out_rsp.ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_req.valid) state_nxt = ST_EXEC;
      ST_EXEC:  if (exec_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // Update path of the access in flight.
  always_comb begin
    cnt_inc = {1'b0, rd_ent.cnt} + (CNT_W + 1)'(1);
    cnt_new = (cnt_inc > {1'b0, cfg.counter_ceiling}) ? cfg.counter_ceiling
                                                      : cnt_inc[CNT_W-1:0];
    hot     = (rd_ent.cnt >= cfg.reuse_thresh);
    again   = rd_ent.vld && (rd_ent.tag == acc_r.ptag) && (rd_ent.addr == acc_r.paddr);
    if (acc_r.hit || hot || again) begin
      new_val = '0;
    end else begin
      new_val = RRPV_W'(RRPV_MAX - 1);
    end
    new_way = acc_r.hit ? acc_r.way : victim;
    new_row = acc_r.hit ? rd_row : aged_row;
    new_row[new_way] = new_val;
  end

  // Memory requests and handshake outputs.
  always_comb begin
    rrpv_req         = '0;
    pc_req           = '0;
    in_req.ready     = 1'b0;
    clr_cnt_nxt      = clr_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt      = clr_cnt_r + CLR_W'(1);
        rrpv_req.wr_en   = (32'(clr_cnt_r) < NUM_SETS);
        rrpv_req.wr_addr = clr_cnt_r[SET_W-1:0];
        rrpv_req.wr_data = '{default: RRPV_W'(RRPV_MAX)};
        pc_req.cnt_we    = (32'(clr_cnt_r) < PC_ENTRIES);
        pc_req.vld_we    = (32'(clr_cnt_r) < PC_ENTRIES);
        pc_req.wr_idx    = clr_cnt_r[PC_W-1:0];
      end
      ST_IDLE: begin
        in_req.ready     = 1'b1;
        rrpv_req.rd_en   = in_req.valid;
        rrpv_req.rd_addr = in_req.set_index[SET_W-1:0];
        pc_req.rd_en     = in_req.valid;
        pc_req.rd_idx    = in_req.pc[PC_W-1:0];
      end
      ST_EXEC: begin
        rrpv_req.wr_en   = exec_go;
        rrpv_req.wr_addr = acc_r.set;
        rrpv_req.wr_data = new_row;
        pc_req.wr_idx    = acc_r.pidx;
        pc_req.cnt_we    = exec_go && acc_r.hit;
        pc_req.vld_we    = exec_go && !acc_r.hit;
        pc_req.rec_we    = exec_go && !acc_r.hit;
        pc_req.wr_data.cnt  = cnt_new;
        pc_req.wr_data.vld  = 1'b1;
        pc_req.wr_data.tag  = acc_r.ptag;
        pc_req.wr_data.addr = acc_r.paddr;
      end
      default: ;
    endcase
  end

  always_comb begin
    acc_nxt = acc_r;
    if (in_go) begin
      acc_nxt.set   = in_req.set_index[SET_W-1:0];
      acc_nxt.hit   = in_req.hit;
      acc_nxt.way   = in_req.hit_way[WAY_W-1:0];
      acc_nxt.pidx  = in_req.pc[PC_W-1:0];
      acc_nxt.ptag  = in_req.pc[ADDR_W-1:PC_W];
      acc_nxt.paddr = in_req.paddr;
    end
  end

  // Result register: load on write-back, drop once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_way_nxt   = out_way_r;
    out_rrpv_nxt  = out_rrpv_r;
    if (exec_go) begin
      out_valid_nxt = 1'b1;
      out_way_nxt   = OUT_WAY_W'(new_way);
      out_rrpv_nxt  = OUT_RRPV_W'(new_val);
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    out_way_r  <= out_way_nxt;
    out_rrpv_r <= out_rrpv_nxt;
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.chosen_way = out_way_r;
  assign out_rsp.new_rrpv   = out_rrpv_r;

  `RRIP_ASSERT(a_accept_to_exec, in_go |=> (state_r == ST_EXEC), "request not executed")
  `RRIP_ASSERT(a_no_rw_overlap, !(rrpv_req.wr_en && rrpv_req.rd_en), "row read and write at once")
  `RRIP_ASSERT(a_clear_once, (state_r != ST_CLEAR) |=> (state_r != ST_CLEAR), "clear re-entered")
  `RRIP_ASSERT(a_hold_in_stall, (state_r == ST_EXEC && !exec_go) |=> $stable(acc_r), "stall moved")
  `RRIP_ASSERT(a_hit_near, (exec_go && acc_r.hit) |=> (out_rrpv_r == '0), "hit result not at zero")

endmodule
